[hdl/fea_pkg.sv]
`default_nettype none
package fea_pkg;

  localparam int MAX_EXTENTS = 64;
  localparam int ADDR_BITS   = 40;
  localparam int IDX_W       = $clog2(MAX_EXTENTS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int SUM_W       = ADDR_BITS + 1;

  typedef logic [1:0] op_t;
  localparam op_t OP_ALLOC = 2'd0;
  localparam op_t OP_FREE  = 2'd1;
  localparam op_t OP_QUERY = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_NOFIT = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_OVF   = 2'd3;

  typedef logic [1:0] strategy_t;
  localparam strategy_t FIT_FIRST = 2'd0;
  localparam strategy_t FIT_BEST  = 2'd1;
  localparam strategy_t FIT_WORST = 2'd2;
  localparam strategy_t FIT_NEXT  = 2'd3;

  localparam logic [SUM_W-1:0] ADDR_LIMIT = SUM_W'(1) << ADDR_BITS;

  // length spans the whole address space when everything is free
  typedef struct packed {
    logic [ADDR_BITS-1:0] offset;
    logic [SUM_W-1:0]     length;
  } extent_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    extent_t          wdata;
    logic [IDX_W-1:0] raddr;
  } ram_ctl_t;

endpackage
`default_nettype wire

[hdl/fea_ifs.sv]
`default_nettype none
interface fea_req_if import fea_pkg::*;;
  logic                 valid;
  logic                 ready;
  op_t                  op;
  logic [ADDR_BITS-1:0] region_start;
  logic [ADDR_BITS-1:0] region_length;
  modport source (output valid, op, region_start, region_length, input ready);
  modport sink (input valid, op, region_start, region_length, output ready);
endinterface

interface fea_rsp_if import fea_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] alloc_start;
  status_t              status;
  logic                 region_is_free;
  logic [SUM_W-1:0]     free_total;
  logic [CNT_W-1:0]     extent_count;
  modport source (output valid, alloc_start, status, region_is_free, free_total,
                  extent_count, input ready);
  modport sink (input valid, alloc_start, status, region_is_free, free_total,
                extent_count, output ready);
endinterface
`default_nettype wire

[hdl/fea_extent_ram.sv]
`default_nettype none
module fea_extent_ram import fea_pkg::*; (
  input  wire logic     clk,
  input  wire ram_ctl_t ctl,
  output extent_t       rdata
);

  extent_t mem [MAX_EXTENTS];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    rdata <= mem[ctl.raddr];
  end

endmodule
`default_nettype wire

[hdl/free_extent_allocator.sv]
`default_nettype none
// Channel | Dir | Payload                                                   | Handshake
// req     | in  | op, region_start, region_length                           | valid/ready
// rsp     | out | alloc_start, status, region_is_free, free_total, ext_count | valid/ready
// cfg     | in  | cfg_wdata (fit strategy)                                  | cfg_we
//
// One request at a time. A request reads the extent table once, one entry per cycle
// through the single read port of the extent RAM, then decides. Removing or inserting
// an extent then moves the entries above it, one per cycle. Zero length, overflow and
// unused ops skip the table and go straight to the final step.
// Reset (rst, synchronous) empties the table; RAM contents are not cleared.
// A waiting response does not block the next request; it only holds the final step.
module free_extent_allocator import fea_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_we,
  input  wire strategy_t cfg_wdata,
  fea_req_if.sink        req,
  fea_rsp_if.source      rsp
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t     state;
  strategy_t  strategy;
  logic [CNT_W-1:0] n, cursor, cstart, k;
  logic [SUM_W-1:0] free_bytes;

  op_t                  op_q;
  logic [ADDR_BITS-1:0] start_q, len_q;

  logic             s_v;
  logic [IDX_W-1:0] s_idx;
  logic             ff_found, cf_found, bp_found, nx_found, hit;
  logic [IDX_W-1:0] ff_idx, cf_idx, bp_idx;
  extent_t          ff_ent, cf_ent, bp_ent, prev_ent, nx_ent;
  logic [CNT_W-1:0] i_cnt;

  logic                 sh_down, p_v, ins_pend;
  logic [CNT_W-1:0]     sh_rd, sh_rem;
  logic [IDX_W-1:0]     p_addr;
  extent_t              ins_ent;

  logic [ADDR_BITS-1:0] res_start;
  status_t              res_status;
  logic                 res_free;

  logic                 out_valid;
  logic [ADDR_BITS-1:0] out_start;
  status_t              out_status;
  logic                 out_free;
  logic [SUM_W-1:0]     out_total;
  logic [CNT_W-1:0]     out_count;

  ram_ctl_t ram_ctl;
  extent_t  rd;

  fea_extent_ram u_ram (.clk(clk), .ctl(ram_ctl), .rdata(rd));

  // scan evaluation
  logic [SUM_W-1:0] end_q, e_end, prev_end, req_end;
  logic             fits, e_le, e_in;
  assign end_q   = {1'b0, start_q} + {1'b0, len_q};
  assign e_end   = {1'b0, rd.offset} + rd.length;
  assign fits    = rd.length >= {1'b0, len_q};
  assign e_le    = rd.offset <= start_q;
  assign e_in    = e_le && (end_q <= e_end);
  assign prev_end = {1'b0, prev_ent.offset} + prev_ent.length;
  assign req_end = {1'b0, req.region_start} + {1'b0, req.region_length};

  // decision
  logic             pk_found, split, lo_ov, hi_ov, low, high;
  logic [IDX_W-1:0] pk_idx;
  extent_t          pk_ent;
  logic [CNT_W-1:0] cur_merge;
  always_comb begin
    case (strategy)
      FIT_FIRST: begin
        pk_found = ff_found; pk_idx = ff_idx; pk_ent = ff_ent;
      end
      FIT_BEST, FIT_WORST: begin
        pk_found = bp_found; pk_idx = bp_idx; pk_ent = bp_ent;
      end
      default: begin
        if (cf_found) begin
          pk_found = 1'b1; pk_idx = cf_idx; pk_ent = cf_ent;
        end else begin
          pk_found = ff_found; pk_idx = ff_idx; pk_ent = ff_ent;
        end
      end
    endcase
    split = pk_ent.length > {1'b0, len_q};
    lo_ov = (i_cnt != '0) && (prev_end > {1'b0, start_q});
    hi_ov = nx_found && ({1'b0, nx_ent.offset} < end_q);
    low   = (i_cnt != '0) && (prev_end == {1'b0, start_q});
    high  = nx_found && ({1'b0, nx_ent.offset} == end_q);
    if (cursor == i_cnt) begin
      cur_merge = i_cnt - CNT_W'(1);
    end else if (cursor > i_cnt) begin
      cur_merge = cursor - CNT_W'(1);
    end else begin
      cur_merge = cursor;
    end
  end

  logic [IDX_W-1:0] i_idx, i_prev_idx;
  assign i_idx      = i_cnt[IDX_W-1:0];
  assign i_prev_idx = i_idx - IDX_W'(1);

  always_comb begin
    ram_ctl.we    = 1'b0;
    ram_ctl.waddr = '0;
    ram_ctl.wdata = '0;
    ram_ctl.raddr = k[IDX_W-1:0];
    case (state)
      S_DECIDE: begin
        if (op_q == OP_ALLOC) begin
          if (pk_found && split) begin
            ram_ctl.we           = 1'b1;
            ram_ctl.waddr        = pk_idx;
            ram_ctl.wdata.offset = pk_ent.offset + len_q;
            ram_ctl.wdata.length = pk_ent.length - {1'b0, len_q};
          end
        end else if (op_q == OP_FREE && !lo_ov && !hi_ov) begin
          if (low) begin
            ram_ctl.we           = 1'b1;
            ram_ctl.waddr        = i_prev_idx;
            ram_ctl.wdata.offset = prev_ent.offset;
            ram_ctl.wdata.length = high ? prev_ent.length + {1'b0, len_q} + nx_ent.length
                                        : prev_ent.length + {1'b0, len_q};
          end else if (high) begin
            ram_ctl.we           = 1'b1;
            ram_ctl.waddr        = i_idx;
            ram_ctl.wdata.offset = start_q;
            ram_ctl.wdata.length = nx_ent.length + {1'b0, len_q};
          end
        end
      end
      S_SHIFT: begin
        ram_ctl.raddr = sh_rd[IDX_W-1:0];
        if (p_v) begin
          ram_ctl.we    = 1'b1;
          ram_ctl.waddr = sh_down ? p_addr - IDX_W'(1) : p_addr + IDX_W'(1);
          ram_ctl.wdata = rd;
        end else if (sh_rem == '0 && ins_pend) begin
          ram_ctl.we    = 1'b1;
          ram_ctl.waddr = i_idx;
          ram_ctl.wdata = ins_ent;
        end
      end
      default: ;
    endcase
  end

  assign req.ready = (state == S_IDLE);

  assign rsp.valid          = out_valid;
  assign rsp.alloc_start    = out_start;
  assign rsp.status         = out_status;
  assign rsp.region_is_free = out_free;
  assign rsp.free_total     = out_total;
  assign rsp.extent_count   = out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      strategy   <= FIT_FIRST;
      n          <= '0;
      cursor     <= '0;
      free_bytes <= '0;
      out_valid  <= 1'b0;
      s_v        <= 1'b0;
      p_v        <= 1'b0;
      ins_pend   <= 1'b0;
    end else begin
      if (cfg_we) begin
        strategy <= cfg_wdata;
      end
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_q       <= req.op;
            start_q    <= req.region_start;
            len_q      <= req.region_length;
            cstart     <= (cursor < n) ? cursor : '0;
            k          <= '0;
            s_v        <= 1'b0;
            ff_found   <= 1'b0;
            cf_found   <= 1'b0;
            bp_found   <= 1'b0;
            nx_found   <= 1'b0;
            hit        <= 1'b0;
            i_cnt      <= '0;
            res_start  <= '0;
            res_free   <= 1'b0;
            if (req.op != OP_ALLOC && req.op != OP_FREE && req.op != OP_QUERY) begin
              res_status <= ST_NOFIT;
              state      <= S_DONE;
            end else if (req.region_length == '0) begin
              res_status <= ST_NOFIT;
              state      <= S_DONE;
            end else if (req.op != OP_ALLOC && req_end > ADDR_LIMIT) begin
              res_status <= ST_OVF;
              state      <= S_DONE;
            end else begin
              res_status <= ST_OK;
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (k < n) begin
            s_v   <= 1'b1;
            s_idx <= k[IDX_W-1:0];
            k     <= k + CNT_W'(1);
          end else begin
            s_v <= 1'b0;
            if (!s_v) begin
              state <= S_DECIDE;
            end
          end
          if (s_v) begin
            if (fits && !ff_found) begin
              ff_found <= 1'b1; ff_idx <= s_idx; ff_ent <= rd;
            end
            if (fits && !cf_found && {1'b0, s_idx} >= cstart) begin
              cf_found <= 1'b1; cf_idx <= s_idx; cf_ent <= rd;
            end
            if (fits && (!bp_found ||
                (strategy == FIT_BEST && rd.length < bp_ent.length) ||
                (strategy == FIT_WORST && rd.length > bp_ent.length))) begin
              bp_found <= 1'b1; bp_idx <= s_idx; bp_ent <= rd;
            end
            if (e_le) begin
              prev_ent <= rd;
              i_cnt    <= CNT_W'(s_idx) + CNT_W'(1);
            end else if (!nx_found) begin
              nx_found <= 1'b1;
              nx_ent   <= rd;
            end
            if (e_in) begin
              hit <= 1'b1;
            end
          end
        end
        S_DECIDE: begin
          case (op_q)
            OP_ALLOC: begin
              if (!pk_found) begin
                res_status <= ST_NOFIT;
                state      <= S_DONE;
              end else begin
                res_start  <= pk_ent.offset;
                free_bytes <= free_bytes - {1'b0, len_q};
                if (split) begin
                  cursor <= CNT_W'(pk_idx);
                  state  <= S_DONE;
                end else begin
                  n       <= n - CNT_W'(1);
                  cursor  <= (CNT_W'(pk_idx) < n - CNT_W'(1)) ? CNT_W'(pk_idx) : '0;
                  sh_down <= 1'b1;
                  sh_rd   <= CNT_W'(pk_idx) + CNT_W'(1);
                  sh_rem  <= n - CNT_W'(1) - CNT_W'(pk_idx);
                  state   <= S_SHIFT;
                end
              end
            end
            OP_FREE: begin
              if (lo_ov || hi_ov) begin
                res_status <= ST_NOFIT;
                state      <= S_DONE;
              end else if (!low && !high && n >= CNT_W'(MAX_EXTENTS)) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                free_bytes <= free_bytes + {1'b0, len_q};
                if (low && high) begin
                  n       <= n - CNT_W'(1);
                  cursor  <= cur_merge;
                  sh_down <= 1'b1;
                  sh_rd   <= i_cnt + CNT_W'(1);
                  sh_rem  <= n - CNT_W'(1) - i_cnt;
                  state   <= S_SHIFT;
                end else if (!low && !high) begin
                  n <= n + CNT_W'(1);
                  if (n == '0) begin
                    cursor <= '0;
                  end else if (cursor >= i_cnt) begin
                    cursor <= cursor + CNT_W'(1);
                  end
                  sh_down        <= 1'b0;
                  sh_rd          <= n - CNT_W'(1);
                  sh_rem         <= n - i_cnt;
                  ins_pend       <= 1'b1;
                  ins_ent.offset <= start_q;
                  ins_ent.length <= {1'b0, len_q};
                  state          <= S_SHIFT;
                end else begin
                  state <= S_DONE;
                end
              end
            end
            default: begin
              res_free <= hit;
              state    <= S_DONE;
            end
          endcase
        end
        S_SHIFT: begin
          if (sh_rem != '0) begin
            p_v    <= 1'b1;
            p_addr <= sh_rd[IDX_W-1:0];
            sh_rd  <= sh_down ? sh_rd + CNT_W'(1) : sh_rd - CNT_W'(1);
            sh_rem <= sh_rem - CNT_W'(1);
          end else begin
            p_v <= 1'b0;
            if (!p_v) begin
              ins_pend <= 1'b0;
              state    <= S_DONE;
            end
          end
        end
        S_DONE: begin
          // hold until the response slot is free
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_start  <= res_start;
            out_status <= res_status;
            out_free   <= res_free;
            out_total  <= free_bytes;
            out_count  <= n;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    n <= CNT_W'(MAX_EXTENTS))
    else $error("extent count past table size");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !ram_ctl.we)
    else $error("table write outside an operation");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == ST_FULL) |-> out_count == CNT_W'(MAX_EXTENTS))
    else $error("table full reported below capacity");

  a_free_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_free) |-> out_status == ST_OK)
    else $error("region free flagged on a failed transaction");

endmodule
`default_nettype wire

[test/tb_free_extent_allocator.sv]
`default_nettype none
module tb_free_extent_allocator;
  import fea_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int SETTLE_CYCLES   = 200;
  localparam logic [SUM_W-1:0] SPACE_END = SUM_W'(1) << ADDR_BITS;
  localparam logic [ADDR_BITS-1:0] MAX_ADDR = '1;

  typedef struct {
    logic [ADDR_BITS-1:0] alloc_start;
    status_t              status;
    logic                 region_is_free;
    logic [SUM_W-1:0]     free_total;
    logic [CNT_W-1:0]     extent_count;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  strategy_t cfg_wdata;

  fea_req_if req_ch();
  fea_rsp_if rsp_ch();

  free_extent_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the free table
  logic [ADDR_BITS-1:0] shadow_off [MAX_EXTENTS];
  logic [SUM_W-1:0]     shadow_len [MAX_EXTENTS];
  int                   shadow_used;
  int                   shadow_cursor;
  logic [SUM_W-1:0]     shadow_free;
  strategy_t            shadow_fit;

  alloc_rsp_t pending_rsp[$];
  bit         failed;
  int         next_gap;
  bit         sender_steady;
  bit         hold_req;
  int         idle_cycles;

  function automatic void drop_extent(int j);
    if (j >= shadow_used) return;
    for (int k = j; k + 1 < shadow_used; k++) begin
      shadow_off[k] = shadow_off[k+1];
      shadow_len[k] = shadow_len[k+1];
    end
    shadow_used--;
    if (shadow_cursor > j) shadow_cursor--;
  endfunction

  function automatic void insert_extent(int i, logic [ADDR_BITS-1:0] off,
                                        logic [SUM_W-1:0] len);
    bit was_empty;
    was_empty = (shadow_used == 0);
    for (int k = shadow_used; k > i; k--) begin
      shadow_off[k] = shadow_off[k-1];
      shadow_len[k] = shadow_len[k-1];
    end
    shadow_off[i] = off;
    shadow_len[i] = len;
    shadow_used++;
    if (was_empty) shadow_cursor = 0;
    else if (shadow_cursor >= i) shadow_cursor++;
  endfunction

  function automatic int choose_extent(logic [SUM_W-1:0] size);
    int n, pick, first;
    n = shadow_used;
    pick = n;
    case (shadow_fit)
      FIT_FIRST: begin
        for (int k = 0; k < n; k++) if (shadow_len[k] >= size) return k;
      end
      FIT_BEST: begin
        for (int k = 0; k < n; k++)
          if (shadow_len[k] >= size && (pick == n || shadow_len[k] < shadow_len[pick]))
            pick = k;
      end
      FIT_WORST: begin
        for (int k = 0; k < n; k++)
          if (shadow_len[k] >= size && (pick == n || shadow_len[k] > shadow_len[pick]))
            pick = k;
      end
      default: begin
        first = (shadow_cursor < n) ? shadow_cursor : 0;
        for (int k = first; k < n; k++) if (shadow_len[k] >= size) return k;
        for (int k = 0; k < first; k++) if (shadow_len[k] >= size) return k;
      end
    endcase
    return pick;
  endfunction

  function automatic bit out_of_space(logic [ADDR_BITS-1:0] s, logic [ADDR_BITS-1:0] l);
    return SUM_W'(l) > SPACE_END - SUM_W'(s);
  endfunction

  function automatic alloc_rsp_t predict_request(op_t op, logic [ADDR_BITS-1:0] s,
                                                 logic [ADDR_BITS-1:0] l);
    alloc_rsp_t r;
    int t, i, n;
    logic [SUM_W-1:0] rend, lo_end;
    bit lo, hi;
    r.alloc_start = '0;
    r.region_is_free = 1'b0;
    r.status = ST_OK;
    n = shadow_used;
    case (op)
      OP_ALLOC: begin
        if (l == 0) r.status = ST_NOFIT;
        else begin
          t = choose_extent(SUM_W'(l));
          if (t >= shadow_used) r.status = ST_NOFIT;
          else begin
            r.alloc_start = shadow_off[t];
            if (shadow_len[t] > SUM_W'(l)) begin
              shadow_off[t] += l;
              shadow_len[t] -= SUM_W'(l);
            end else drop_extent(t);
            shadow_cursor = (t < shadow_used) ? t : 0;
            shadow_free -= SUM_W'(l);
          end
        end
      end
      OP_FREE: begin
        if (l == 0) r.status = ST_NOFIT;
        else if (out_of_space(s, l)) r.status = ST_OVF;
        else begin
          rend = SUM_W'(s) + SUM_W'(l);
          i = 0;
          while (i < n && shadow_off[i] <= s) i++;
          lo_end = (i > 0) ? SUM_W'(shadow_off[i-1]) + shadow_len[i-1] : '0;
          if (i > 0 && lo_end > SUM_W'(s)) r.status = ST_NOFIT;
          else if (i < n && SUM_W'(shadow_off[i]) < rend) r.status = ST_NOFIT;
          else begin
            lo = (i > 0) && (lo_end == SUM_W'(s));
            hi = (i < n) && (SUM_W'(shadow_off[i]) == rend);
            if (lo && hi) begin
              shadow_len[i-1] += SUM_W'(l) + shadow_len[i];
              if (shadow_cursor == i) shadow_cursor = i - 1;
              drop_extent(i);
            end else if (lo) begin
              shadow_len[i-1] += SUM_W'(l);
            end else if (hi) begin
              shadow_off[i] = s;
              shadow_len[i] += SUM_W'(l);
            end else if (n >= MAX_EXTENTS) begin
              r.status = ST_FULL;
            end else begin
              insert_extent(i, s, SUM_W'(l));
            end
            if (r.status == ST_OK) shadow_free += SUM_W'(l);
          end
        end
      end
      OP_QUERY: begin
        if (l == 0) r.status = ST_NOFIT;
        else if (out_of_space(s, l)) r.status = ST_OVF;
        else begin
          for (int k = 0; k < shadow_used; k++)
            if (shadow_off[k] <= s &&
                SUM_W'(s) + SUM_W'(l) <= SUM_W'(shadow_off[k]) + shadow_len[k]) begin
              r.region_is_free = 1'b1;
              break;
            end
        end
      end
      default: r.status = ST_NOFIT;
    endcase
    r.free_total = shadow_free;
    r.extent_count = CNT_W'(shadow_used);
    return r;
  endfunction

  function automatic int draw_gap();
    int p;
    if (sender_steady) return 0;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  task automatic send_request(op_t op, logic [ADDR_BITS-1:0] s, logic [ADDR_BITS-1:0] l);
    if (next_gap > 0) begin
      repeat (next_gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.op            <= op;
    req_ch.region_start  <= s;
    req_ch.region_length <= l;
    do @(posedge clk); while (!req_ch.ready);
    pending_rsp.insert(pending_rsp.size(), predict_request(op, s, l));
    next_gap = draw_gap();
    // keep valid up only when the next transaction follows at once
    if (next_gap > 0) req_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    if (next_gap == 0) req_ch.valid <= 1'b0;
    next_gap = 0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic set_fit(strategy_t fit);
    wait_drained();
    // idle before the strategy write; table moves already end before each response
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= fit;
    @(posedge clk);
    cfg_we    <= 1'b0;
    shadow_fit = fit;
  endtask

  always @(posedge clk) begin
    alloc_rsp_t e;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("response with nothing pending");
        failed = 1'b1;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_ch.alloc_start !== e.alloc_start) begin
          $error("alloc_start expected %0h got %0h", e.alloc_start, rsp_ch.alloc_start);
          failed = 1'b1;
        end
        if (rsp_ch.status !== e.status) begin
          $error("status expected %0d got %0d", e.status, rsp_ch.status);
          failed = 1'b1;
        end
        if (rsp_ch.region_is_free !== e.region_is_free) begin
          $error("region_is_free expected %0d got %0d", e.region_is_free,
                 rsp_ch.region_is_free);
          failed = 1'b1;
        end
        if (rsp_ch.free_total !== e.free_total) begin
          $error("free_total expected %0h got %0h", e.free_total, rsp_ch.free_total);
          failed = 1'b1;
        end
        if (rsp_ch.extent_count !== e.extent_count) begin
          $error("extent_count expected %0d got %0d", e.extent_count, rsp_ch.extent_count);
          failed = 1'b1;
        end
      end
    end
  end

  // response back-pressure
  int hold_left = 0;
  int stall_left = 0;
  int ready_cyc = 0;
  always @(posedge clk) begin
    ready_cyc++;
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (ready_cyc[8]) begin
      rsp_ch.ready <= 1'b1;
    end else begin
      if ($urandom_range(0, 99) < 2) stall_left = $urandom_range(20, 80);
      rsp_ch.ready <= ($urandom_range(0, 99) < 65);
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == WATCHDOG_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(OP_ALLOC, '0, 40'd5);
    send_request(OP_ALLOC, '0, '0);
    send_request(OP_FREE, 40'd10, '0);
    send_request(OP_QUERY, 40'd10, '0);
    send_request(op_t'(2'd3), MAX_ADDR, MAX_ADDR);
    send_request(OP_FREE, MAX_ADDR - 40'd15, 40'd17);
    send_request(OP_QUERY, MAX_ADDR - 40'd15, 40'd17);
    send_request(OP_FREE, MAX_ADDR, MAX_ADDR);
    send_request(OP_FREE, MAX_ADDR - 40'd15, 40'd16);
    send_request(OP_QUERY, MAX_ADDR - 40'd15, 40'd16);
    send_request(OP_FREE, 40'd100, 40'd50);
    send_request(OP_FREE, 40'd300, 40'd20);
    send_request(OP_FREE, 40'd200, 40'd10);
    send_request(OP_FREE, 40'd150, 40'd50);
    send_request(OP_FREE, 40'd120, 40'd5);
    send_request(OP_FREE, 40'd210, 40'd90);
    send_request(OP_FREE, 40'd400, 40'd8);
    send_request(OP_FREE, 40'd392, 40'd8);
    send_request(OP_QUERY, 40'd0, 40'd1);
    send_request(OP_QUERY, 40'd120, 40'd10);
    send_request(OP_QUERY, 40'd100, 40'd221);
    send_request(OP_ALLOC, '0, MAX_ADDR);
    send_request(OP_ALLOC, '0, 40'd3);
  endtask

  task automatic test_strategies();
    for (int f = 0; f < 4; f++) begin
      set_fit(strategy_t'(f));
      send_request(OP_FREE, 40'd1000 + 40'(f * 100), 40'd4);
      send_request(OP_ALLOC, '0, 40'd2);
      send_request(OP_ALLOC, '0, 40'd6);
      send_request(OP_ALLOC, '0, 40'd1);
    end
  endtask

  task automatic test_table_full();
    set_fit(FIT_NEXT);
    for (int k = 0; k < 70; k++) send_request(OP_FREE, 40'h1_0000 + 40'(k * 4), 40'd1);
    for (int k = 0; k < 10; k++)
      send_request(OP_ALLOC, '0, 40'($urandom_range(1, 3)));
    send_request(OP_FREE, 40'h1_0000 + 40'd2, 40'd2);
  endtask

  task automatic test_back_pressure();
    hold_req = 1'b1;
    for (int k = 0; k < 12; k++)
      send_request(op_t'($urandom_range(0, 2)), 40'h2_0000 + 40'(k * 3), 40'd2);
    wait_drained();
  endtask

  task automatic test_random(int count);
    logic [ADDR_BITS-1:0] base, s, l;
    op_t op;
    int p;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        p = $urandom_range(0, 2);
        base = (p == 0) ? '0 : (p == 1) ? ADDR_BITS'({$urandom(), $urandom()}) :
                                          MAX_ADDR - 40'd2047;
        base[11:0] = '0;
        if (p == 2) base = MAX_ADDR - 40'd4095;
        sender_steady = ($urandom_range(0, 3) == 0);
      end
      p = $urandom_range(0, 99);
      if (p < 5) begin
        op = op_t'($urandom_range(0, 3));
        s  = ADDR_BITS'({$urandom(), $urandom()});
        l  = ($urandom_range(0, 1)) ? ADDR_BITS'({$urandom(), $urandom()})
                                    : 40'($urandom_range(0, 3));
      end else begin
        op = (p < 45) ? OP_FREE : (p < 80) ? OP_ALLOC : OP_QUERY;
        s  = base + 40'($urandom_range(0, 4095));
        l  = 40'($urandom_range(1, (op == OP_ALLOC) ? 96 : 48));
      end
      send_request(op, s, l);
    end
    sender_steady = 1'b0;
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.op = OP_ALLOC;
    req_ch.region_start = '0;
    req_ch.region_length = '0;
    rsp_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = FIT_FIRST;
    failed = 1'b0;
    hold_req = 1'b0;
    sender_steady = 1'b0;
    idle_cycles = 0;
    shadow_used = 0;
    shadow_cursor = 0;
    shadow_free = '0;
    shadow_fit = FIT_FIRST;
    next_gap = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_strategies();
    test_table_full();
    test_back_pressure();
    set_fit(FIT_FIRST);
    test_random(120);
    set_fit(FIT_BEST);
    test_random(120);
    set_fit(FIT_WORST);
    test_random(120);
    set_fit(FIT_NEXT);
    test_random(120);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!failed) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
hdl/fea_pkg.sv
hdl/fea_ifs.sv
hdl/fea_extent_ram.sv
hdl/free_extent_allocator.sv
test/tb_free_extent_allocator.sv
